// File: rtl/core/ufs_pkg.sv
// Shared types, character codes and phase/mark codes for the URL field splitter.
`timescale 1ns / 1ps

package ufs_pkg;

  localparam int MAX_URL_BYTES_DEF = 2048;

  localparam int START_W  = 11;
  localparam int LEN_W    = 12;
  localparam int QSTART_W = 12;
  localparam int PORT_W   = 16;
  localparam int PH_W     = 3;

  // parse phases
  localparam logic [PH_W-1:0] PH_START   = 3'd0;
  localparam logic [PH_W-1:0] PH_SCHEME  = 3'd1;
  localparam logic [PH_W-1:0] PH_SLASHES = 3'd2;
  localparam logic [PH_W-1:0] PH_HOST    = 3'd3;
  localparam logic [PH_W-1:0] PH_PORT    = 3'd4;
  localparam logic [PH_W-1:0] PH_PATH    = 3'd5;
  localparam logic [PH_W-1:0] PH_QUERY   = 3'd6;

  // field mark slots
  localparam int MK_SCH_B  = 0;
  localparam int MK_SCH_E  = 1;
  localparam int MK_HOST_B = 2;
  localparam int MK_HOST_E = 3;
  localparam int MK_PORT_B = 4;
  localparam int MK_PORT_E = 5;
  localparam int MK_PATH_B = 6;
  localparam int MK_PATH_E = 7;
  localparam int MK_QRY_B  = 8;
  localparam int MK_QRY_E  = 9;
  localparam int MK_NUM    = 10;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  localparam logic [PORT_W-1:0] PORT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_req;
  } ufs_in_t;

  typedef struct packed {
    logic                status;
    logic [START_W-1:0]  scheme_start;
    logic [LEN_W-1:0]    scheme_len;
    logic [START_W-1:0]  host_pos;
    logic [LEN_W-1:0]    host_len;
    logic                port_present;
    logic [PORT_W-1:0]   port_value;
    logic [START_W-1:0]  path_pos;
    logic [LEN_W-1:0]    path_len;
    logic                query_present;
    logic [QSTART_W-1:0] query_pos;
    logic [LEN_W-1:0]    query_len;
  } ufs_out_t;

  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic              stopped;
    logic              failed;
    logic [MK_NUM-1:0] seen;
  } ufs_ctl_t;

endpackage

// File: rtl/core/ufs_step.sv
// Next-state logic of the parser: one URL byte against the current phase.
`timescale 1ns / 1ps

module ufs_step import ufs_pkg::*; #(
  parameter int MAX_URL_BYTES = MAX_URL_BYTES_DEF,
  localparam int OFF_W = $clog2(MAX_URL_BYTES + 1)
) (
  input  ufs_ctl_t                       ctl,
  input  logic [OFF_W-1:0]               off,
  input  logic [MK_NUM-1:0][OFF_W-1:0]   marks,
  input  logic [PORT_W-1:0]              acc,
  input  logic [7:0]                     char_in,
  output ufs_ctl_t                       ctl_nxt,
  output logic [OFF_W-1:0]               off_nxt,
  output logic [MK_NUM-1:0][OFF_W-1:0]   marks_nxt,
  output logic [PORT_W-1:0]              acc_nxt
);

  logic             is_ws;
  logic             is_letter;
  logic             is_dig;
  logic [7:0]       lc;
  logic [OFF_W-1:0] off_inc;
  logic [19:0]      port_sum;

  assign lc        = char_in | CH_SPACE;
  assign is_ws     = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
  assign is_letter = (lc >= CH_LC_A) && (lc <= CH_LC_Z);
  assign is_dig    = (char_in >= CH_DIG0) && (char_in <= CH_DIG9);
  assign off_inc   = off + OFF_W'(1);

  // acc*10 + digit as two shifted adds
  assign port_sum = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(char_in - CH_DIG0);

  always_comb begin
    ctl_nxt   = ctl;
    off_nxt   = off;
    marks_nxt = marks;
    acc_nxt   = acc;
    if (!ctl.stopped && !ctl.failed && off < OFF_W'(MAX_URL_BYTES)) begin
      if (char_in == CH_NUL) begin
        ctl_nxt.stopped = 1'b1;
      end else begin
        unique case (ctl.phase)
          PH_START: begin
            if (is_ws) begin
            end else if (is_letter) begin
              marks_nxt[MK_SCH_B]    = off;
              ctl_nxt.seen[MK_SCH_B] = 1'b1;
              ctl_nxt.phase          = PH_SCHEME;
            end else if (char_in == CH_SLASH) begin
              marks_nxt[MK_PATH_B]    = off;
              ctl_nxt.seen[MK_PATH_B] = 1'b1;
              ctl_nxt.phase           = PH_PATH;
            end else begin
              ctl_nxt.failed = 1'b1;
            end
          end
          PH_SCHEME: begin
            if (is_letter) begin
            end else if (char_in == CH_COLON) begin
              marks_nxt[MK_SCH_E]    = off;
              ctl_nxt.seen[MK_SCH_E] = 1'b1;
              ctl_nxt.phase          = PH_SLASHES;
            end else begin
              ctl_nxt.failed = 1'b1;
            end
          end
          PH_SLASHES: begin
            if (char_in == CH_SLASH) begin
            end else if (is_letter) begin
              marks_nxt[MK_HOST_B]    = off;
              ctl_nxt.seen[MK_HOST_B] = 1'b1;
              ctl_nxt.phase           = PH_HOST;
            end else begin
              ctl_nxt.failed = 1'b1;
            end
          end
          PH_HOST: begin
            if (is_letter || is_dig || char_in == CH_DOT || char_in == CH_DASH) begin
            end else if (char_in == CH_COLON) begin
              marks_nxt[MK_HOST_E]    = off;
              ctl_nxt.seen[MK_HOST_E] = 1'b1;
              marks_nxt[MK_PORT_B]    = off_inc;
              ctl_nxt.seen[MK_PORT_B] = 1'b1;
              ctl_nxt.phase           = PH_PORT;
            end else if (char_in == CH_SLASH) begin
              marks_nxt[MK_HOST_E]    = off;
              ctl_nxt.seen[MK_HOST_E] = 1'b1;
              marks_nxt[MK_PATH_B]    = off;
              ctl_nxt.seen[MK_PATH_B] = 1'b1;
              ctl_nxt.phase           = PH_PATH;
            end else begin
              ctl_nxt.failed = 1'b1;
            end
          end
          PH_PORT: begin
            if (is_dig) begin
              acc_nxt = (|port_sum[19:16]) ? PORT_MAX : port_sum[15:0];
            end else if (char_in == CH_SLASH) begin
              marks_nxt[MK_PORT_E]    = off;
              ctl_nxt.seen[MK_PORT_E] = 1'b1;
              marks_nxt[MK_PATH_B]    = off;
              ctl_nxt.seen[MK_PATH_B] = 1'b1;
              ctl_nxt.phase           = PH_PATH;
            end else if (is_ws) begin
              marks_nxt[MK_PORT_E]    = off;
              ctl_nxt.seen[MK_PORT_E] = 1'b1;
              ctl_nxt.stopped         = 1'b1;
            end else begin
              ctl_nxt.failed = 1'b1;
            end
          end
          PH_PATH: begin
            if (char_in == CH_QMARK) begin
              marks_nxt[MK_PATH_E]    = off;
              ctl_nxt.seen[MK_PATH_E] = 1'b1;
              marks_nxt[MK_QRY_B]     = off_inc;
              ctl_nxt.seen[MK_QRY_B]  = 1'b1;
              ctl_nxt.phase           = PH_QUERY;
            end else if (char_in == CH_HASH || is_ws) begin
              marks_nxt[MK_PATH_E]    = off;
              ctl_nxt.seen[MK_PATH_E] = 1'b1;
              ctl_nxt.stopped         = 1'b1;
            end
          end
          PH_QUERY: begin
            if (char_in == CH_HASH || is_ws) begin
              marks_nxt[MK_QRY_E]    = off;
              ctl_nxt.seen[MK_QRY_E] = 1'b1;
              ctl_nxt.stopped        = 1'b1;
            end
          end
          default: ctl_nxt.failed = 1'b1;
        endcase
        if (!ctl_nxt.stopped && !ctl_nxt.failed) begin
          off_nxt = off_inc;
        end
      end
    end
  end

endmodule

// File: rtl/core/ufs_emit.sv
// Result builder: turns the field marks into start/length fields or a failure.
`timescale 1ns / 1ps

module ufs_emit import ufs_pkg::*; #(
  parameter int MAX_URL_BYTES = MAX_URL_BYTES_DEF,
  localparam int OFF_W = $clog2(MAX_URL_BYTES + 1),
  localparam int W     = (OFF_W > LEN_W) ? OFF_W : LEN_W
) (
  input  ufs_ctl_t                     ctl,
  input  logic [OFF_W-1:0]             off,
  input  logic [MK_NUM-1:0][OFF_W-1:0] marks,
  input  logic [PORT_W-1:0]            acc,
  output ufs_out_t                     res
);

  logic           bad;
  logic [W-1:0]   sch_b, sch_e, host_b, host_e, path_b, path_e, qry_b, qry_e;
  logic [W-1:0]   end_pos;

  assign sch_b   = W'(marks[MK_SCH_B]);
  assign sch_e   = W'(marks[MK_SCH_E]);
  assign host_b  = W'(marks[MK_HOST_B]);
  assign host_e  = W'(marks[MK_HOST_E]);
  assign path_b  = W'(marks[MK_PATH_B]);
  assign qry_b   = W'(marks[MK_QRY_B]);
  assign end_pos = W'(off);

  // open path or query runs to the end of the string
  assign path_e = ctl.seen[MK_PATH_E] ? W'(marks[MK_PATH_E]) : end_pos;

  always_comb begin
    qry_e = ctl.seen[MK_QRY_E] ? W'(marks[MK_QRY_E]) : end_pos;
    if (qry_e < qry_b) begin
      qry_e = qry_b;
    end
  end

  assign bad = ctl.failed
             || (ctl.seen[MK_SCH_B]  && !ctl.seen[MK_SCH_E])
             || (ctl.seen[MK_HOST_B] && !ctl.seen[MK_HOST_E])
             || (ctl.seen[MK_PORT_B] && !ctl.seen[MK_PORT_E]);

  always_comb begin
    res = '0;
    if (bad) begin
      res.status = 1'b1;
    end else begin
      if (ctl.seen[MK_SCH_B]) begin
        res.scheme_start = sch_b[START_W-1:0];
        res.scheme_len   = LEN_W'(sch_e - sch_b);
      end
      if (ctl.seen[MK_HOST_B]) begin
        res.host_pos = host_b[START_W-1:0];
        res.host_len = LEN_W'(host_e - host_b);
      end
      if (ctl.seen[MK_PORT_B]) begin
        res.port_present = 1'b1;
        res.port_value   = acc;
      end
      if (ctl.seen[MK_PATH_B]) begin
        res.path_pos = path_b[START_W-1:0];
        res.path_len = LEN_W'(path_e - path_b);
      end
      if (ctl.seen[MK_QRY_B]) begin
        res.query_present = 1'b1;
        res.query_pos     = qry_b[QSTART_W-1:0];
        res.query_len     = LEN_W'(qry_e - qry_b);
      end
    end
  end

endmodule

// File: rtl/core/url_field_splitter_core.sv
// Top level of the URL field splitter: input register, parse state and result register.
`timescale 1ns / 1ps

// URL field splitter.
// Input channel (in_valid / in_stall / in_data): one URL byte per item, with
// final_req set on the last byte of the string. Result channel (out_valid /
// out_stall / out_data): one item per URL, issued for the byte marked final.
// An accepted byte sits in the input register while the phase logic works on
// it; the parse state and, for a final byte, the result register load from it
// when it advances, so out_valid follows the final byte through the input
// register and then the result register. Throughput is one byte per cycle
// unless a final byte waits on a stalled result; the only loop is the parse
// state update. After a final byte the parse state returns to its start values, so the
// next byte begins a new URL with no gap.
// If the receiver stalls, the pending result holds; ordinary bytes keep
// flowing, and only a following final byte waits in the input register,
// which raises in_stall until the result is taken.
// Reset (rst_n low, synchronous) empties both registers and clears the
// parse state to the start phase.

module url_field_splitter_core import ufs_pkg::*; #(
  parameter int MAX_URL_BYTES = MAX_URL_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ufs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ufs_out_t out_data
);

  localparam int OFF_W = $clog2(MAX_URL_BYTES + 1);

  logic                     in_vld_r;
  ufs_in_t                  in_data_r;
  logic                     adv;
  logic                     in_take;

  ufs_ctl_t                 ctl_r, ctl_nxt;
  logic [OFF_W-1:0]         off_r, off_nxt;
  logic [MK_NUM-1:0][OFF_W-1:0] marks_r, marks_nxt;
  logic [PORT_W-1:0]        acc_r, acc_nxt;

  logic                     out_vld_r;
  ufs_out_t                 out_data_r;
  ufs_out_t                 res;

  // a final byte needs a free result register; other bytes always move on
  assign adv      = in_vld_r && (!in_data_r.final_req || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  ufs_step #(.MAX_URL_BYTES(MAX_URL_BYTES)) u_step (
    .ctl       (ctl_r),
    .off       (off_r),
    .marks     (marks_r),
    .acc       (acc_r),
    .char_in   (in_data_r.char_in),
    .ctl_nxt   (ctl_nxt),
    .off_nxt   (off_nxt),
    .marks_nxt (marks_nxt),
    .acc_nxt   (acc_nxt)
  );

  ufs_emit #(.MAX_URL_BYTES(MAX_URL_BYTES)) u_emit (
    .ctl   (ctl_nxt),
    .off   (off_nxt),
    .marks (marks_nxt),
    .acc   (acc_nxt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{phase: PH_START, stopped: 1'b0, failed: 1'b0, seen: '0};
      off_r <= '0;
      acc_r <= '0;
    end else if (adv) begin
      if (in_data_r.final_req) begin
        ctl_r <= '{phase: PH_START, stopped: 1'b0, failed: 1'b0, seen: '0};
        off_r <= '0;
        acc_r <= '0;
      end else begin
        ctl_r <= ctl_nxt;
        off_r <= off_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  // mark values are qualified by the seen bits
  always_ff @(posedge clk) begin
    if (adv) begin
      marks_r <= marks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && in_data_r.final_req) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_data_r.final_req) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_new_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !(adv && in_data_r.final_req)) |=> (!out_vld_r || $stable(out_data_r)))
    else $error("result changed without a final item");

  a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_data_r.final_req) |=> (ctl_r.phase == PH_START && off_r == '0 &&
                                      ctl_r.seen == '0))
    else $error("parse state not cleared after final item");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.status) |-> (out_data_r.scheme_len == '0 &&
      out_data_r.host_len == '0 && !out_data_r.port_present &&
      out_data_r.path_len == '0 && !out_data_r.query_present))
    else $error("failure result carries field data");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= OFF_W'(MAX_URL_BYTES))
    else $error("byte offset beyond maximum URL length");
`endif

endmodule
